>>> sv/cis_pkg.sv
// shared types, constants and helpers for the 2d contact impulse solver
package cis_pkg;

    // request function codes
    localparam logic FUNC_VEL = 1'b0;
    localparam logic FUNC_POS = 1'b1;

    // configuration register indexes
    localparam logic REG_SLOP = 1'b0;
    localparam logic REG_PCT  = 1'b1;

    localparam logic [16:0] SLOP_RESET = 17'd655;
    localparam logic [16:0] PCT_RESET  = 17'd52429;

    // divider geometry: 54 bit dividend, 32 bit divisor, 33 quotient bits
    localparam int NUM_W = 54;
    localparam int DIV_W = 32;
    localparam int QUO_W = 33;

    // per-request context that travels down the pipeline
    typedef struct packed {
        logic               func;
        logic               skip;
        logic               neg;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic        [30:0] ima;
        logic        [30:0] imb;
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        logic        [16:0] e;
        logic        [17:0] mu;
        logic        [32:0] maxf;
        logic        [31:0] invs;
    } ctx_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> sv/cis_div.sv
// pipelined restoring divider, one quotient bit per stage, with context sideband
module cis_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  cis_pkg::ctx_t               in_ctx,
    input  logic [cis_pkg::NUM_W-1:0]   dividend,
    output logic                        out_valid,
    output cis_pkg::ctx_t               out_ctx,
    output logic [cis_pkg::QUO_W-1:0]   quotient,
    output logic                        overflow
);

    localparam int QW = cis_pkg::QUO_W;
    localparam int DW = cis_pkg::DIV_W;
    localparam int NW = cis_pkg::NUM_W;

    logic                valid_reg [0:QW];
    cis_pkg::ctx_t       ctx_reg   [0:QW];
    logic [DW-1:0]       rem_reg   [0:QW];
    logic [QW-1:0]       low_reg   [0:QW];
    logic [QW-1:0]       quo_reg   [0:QW];
    logic                ovf_reg   [0:QW];

    logic [DW-1:0]       top_next;

    // upper dividend bits must stay below the divisor, else the quotient overflows
    assign top_next = DW'(dividend[NW-1:QW]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx_reg[0] <= in_ctx;
            ovf_reg[0] <= (top_next >= in_ctx.invs);
            rem_reg[0] <= top_next;
            low_reg[0] <= dividend[QW-1:0];
            quo_reg[0] <= '0;
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_step
        logic [DW:0]   shf_next;
        logic          ge_next;
        logic [DW-1:0] rem_next;

        always_comb
        begin
            shf_next = {rem_reg[k-1], low_reg[k-1][QW-1]};
            ge_next  = (shf_next >= {1'b0, ctx_reg[k-1].invs});
            rem_next = ge_next ? DW'(shf_next - {1'b0, ctx_reg[k-1].invs})
                               : shf_next[DW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ctx_reg[k] <= ctx_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
                rem_reg[k] <= rem_next;
                low_reg[k] <= {low_reg[k-1][QW-2:0], 1'b0};
                quo_reg[k] <= {quo_reg[k-1][QW-2:0], ge_next};
            end
        end
    end

    assign out_valid = valid_reg[QW];
    assign out_ctx   = ctx_reg[QW];
    assign quotient  = quo_reg[QW];
    assign overflow  = ovf_reg[QW];

endmodule

>>> sv/contact_impulse_solver_2d.sv
// top level of the 2d contact impulse solver pipeline
// both functions take the same pipeline path, so results leave in request order
// throughput: one request per cycle unless output stalls; two 34 stage dividers set the depth
// a stalled output freezes the whole pipeline, so nothing is lost or repeated
// reset: asynchronous active low, clears all valid bits, slop 655 and percent 52429
module contact_impulse_solver_2d (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic        [30:0] inv_mass_a,
    input  logic        [30:0] inv_mass_b,
    input  logic signed [17:0] normal_x,
    input  logic signed [17:0] normal_y,
    input  logic        [16:0] restitution,
    input  logic        [17:0] friction_coef,
    input  logic        [30:0] penetration,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] new_a_x,
    output logic signed [31:0] new_a_y,
    output logic signed [31:0] new_b_x,
    output logic signed [31:0] new_b_y,
    output logic               applied,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic        [16:0] cfg_data
);

    // configuration registers
    logic [16:0] slop_reg;
    logic [16:0] pct_reg;

    // global advance: the whole pipeline moves unless the output holds a stalled result
    logic adv;

    // valid bits and context for the stages outside the dividers
    logic          v_reg  [1:21];
    logic          v_next [1:21];
    cis_pkg::ctx_t c_reg  [1:21];
    cis_pkg::ctx_t c_next [1:21];

    // stage 1: relative velocity, excess penetration
    logic signed [32:0] rvx_reg, rvx_next, rvy_reg, rvy_next;
    logic        [30:0] pen_reg [1:3];
    logic        [30:0] pen_next [1:3];
    // stage 2: normal projection products
    logic signed [50:0] px_reg, px_next, py_reg, py_next;
    // stage 3: approach speed
    logic signed [35:0] vn_reg, vn_next;
    // stage 4: dividend of the normal impulse or the position correction
    logic        [53:0] num_reg, num_next;
    // first divider output
    logic               d1_valid, d1_ovf;
    cis_pkg::ctx_t      d1_ctx;
    logic        [32:0] d1_q;
    // stage 5..7: impulse magnitude, friction bound, correction scale
    logic        [30:0] jq5_reg, jq5_next, jq6_reg, jq6_next, sc_reg, sc_next;
    logic        [47:0] ps_reg, ps_next;
    logic        [48:0] pf_reg, pf_next;
    // stage 8..10: normal impulse vector and mass weighting
    logic signed [49:0] cnx_reg, cnx_next, cny_reg, cny_next;
    logic signed [31:0] ix_reg, ix_next, iy_reg, iy_next;
    logic signed [62:0] dax_reg, dax_next, day_reg, day_next;
    logic signed [62:0] dbx_reg, dbx_next, dby_reg, dby_next;
    // stage 12..15: tangential relative velocity and its dividend
    logic signed [32:0] rv2x_reg, rv2x_next, rv2y_reg, rv2y_next;
    logic signed [18:0] nny13, nny18;
    logic signed [51:0] pt1_reg, pt1_next, pt2_reg, pt2_next;
    logic signed [52:0] tn_reg, tn_next;
    logic        [53:0] mag_reg, mag_next;
    // second divider output
    logic               d2_valid, d2_ovf;
    cis_pkg::ctx_t      d2_ctx;
    logic        [32:0] d2_q;
    // stage 16..20: clamped friction impulse and mass weighting
    logic        [32:0] jc_reg, jc_next;
    logic signed [33:0] jt_reg, jt_next;
    logic signed [52:0] tpx_reg, tpx_next, tpy_reg, tpy_next;
    logic signed [31:0] tix_reg, tix_next, tiy_reg, tiy_next;
    logic signed [62:0] eax_reg, eax_next, eay_reg, eay_next;
    logic signed [62:0] ebx_reg, ebx_next, eby_reg, eby_next;

    assign adv      = !v_reg[21] || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slop_reg <= cis_pkg::SLOP_RESET;
            pct_reg  <= cis_pkg::PCT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == cis_pkg::REG_SLOP)
            begin
                slop_reg <= cfg_data;
            end
            else
            begin
                pct_reg <= cfg_data;
            end
        end
    end

    // valid bits follow the data; the dividers carry their own
    always_comb
    begin
        v_next[1] = in_valid;
        for (int k = 2; k <= 21; k++)
        begin
            v_next[k] = v_reg[k-1];
        end
        v_next[5]  = d1_valid;
        v_next[16] = d2_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= 21; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            for (int k = 1; k <= 21; k++)
            begin
                v_reg[k] <= v_next[k];
            end
        end
    end

    // datapath next values, one stage per group
    always_comb
    begin
        for (int k = 2; k <= 21; k++)
        begin
            c_next[k] = c_reg[k-1];
        end

        // stage 1: capture the request
        c_next[1].func = func;
        c_next[1].skip = 1'b0;
        c_next[1].neg  = 1'b0;
        c_next[1].ax   = a_x;
        c_next[1].ay   = a_y;
        c_next[1].bx   = b_x;
        c_next[1].by   = b_y;
        c_next[1].ima  = inv_mass_a;
        c_next[1].imb  = inv_mass_b;
        c_next[1].nx   = normal_x;
        c_next[1].ny   = normal_y;
        c_next[1].e    = restitution;
        c_next[1].mu   = friction_coef;
        c_next[1].maxf = '0;
        c_next[1].invs = {1'b0, inv_mass_a} + {1'b0, inv_mass_b};
        rvx_next    = b_x - a_x;
        rvy_next    = b_y - a_y;
        pen_next[1] = (penetration > {14'd0, slop_reg})
                    ? penetration - {14'd0, slop_reg} : '0;

        // stage 2: project relative velocity onto the normal
        px_next     = rvx_reg * $signed(c_reg[1].nx);
        py_next     = rvy_reg * $signed(c_reg[1].ny);
        pen_next[2] = pen_reg[1];

        // stage 3: floor shift; skip when both static, or when separating on a velocity request
        vn_next        = 36'(({px_reg[50], px_reg} + {py_reg[50], py_reg}) >>> 16);
        pen_next[3]    = pen_reg[2];
        c_next[3].skip = (c_reg[2].invs == '0)
                       || (c_reg[2].func == cis_pkg::FUNC_VEL
                           && !vn_next[35] && vn_next != '0);

        // stage 4: (1 + e) * -vn, or penetration scaled to Q16.16
        if (c_reg[3].func == cis_pkg::FUNC_POS)
        begin
            num_next = {7'd0, pen_reg[3], 16'd0};
        end
        else
        begin
            num_next = ({1'b0, c_reg[3].e} + 18'd65536) * 36'(-vn_reg);
        end

        // stage 5: saturate quotient, zero it for skipped requests
        c_next[5] = d1_ctx;
        if (d1_ctx.skip)
        begin
            jq5_next = '0;
        end
        else if (d1_ovf || d1_q[32:31] != 2'b00)
        begin
            jq5_next = '1;
        end
        else
        begin
            jq5_next = d1_q[30:0];
        end

        // stage 6: correction percent and friction bound products
        jq6_next = jq5_reg;
        ps_next  = jq5_reg * pct_reg;
        pf_next  = c_reg[5].mu * jq5_reg;

        // stage 7: pick the scalar along the normal
        if (c_reg[6].func == cis_pkg::FUNC_POS)
        begin
            sc_next        = ps_reg[47] ? '1 : ps_reg[46:16];
            c_next[7].maxf = '0;
        end
        else
        begin
            sc_next        = jq6_reg;
            c_next[7].maxf = pf_reg[48:16];
        end

        // stage 8..9: impulse vector
        cnx_next = $signed({1'b0, sc_reg}) * $signed(c_reg[7].nx);
        cny_next = $signed({1'b0, sc_reg}) * $signed(c_reg[7].ny);
        ix_next  = cis_pkg::sat32(64'($signed(cnx_reg[49:16])));
        iy_next  = cis_pkg::sat32(64'($signed(cny_reg[49:16])));

        // stage 10..11: weight by inverse mass and apply
        dax_next = ix_reg * $signed({1'b0, c_reg[9].ima});
        day_next = iy_reg * $signed({1'b0, c_reg[9].ima});
        dbx_next = ix_reg * $signed({1'b0, c_reg[9].imb});
        dby_next = iy_reg * $signed({1'b0, c_reg[9].imb});
        c_next[11].ax = cis_pkg::sat32(64'($signed(c_reg[10].ax))
                                       - 64'($signed(dax_reg[62:16])));
        c_next[11].ay = cis_pkg::sat32(64'($signed(c_reg[10].ay))
                                       - 64'($signed(day_reg[62:16])));
        c_next[11].bx = cis_pkg::sat32(64'($signed(c_reg[10].bx))
                                       + 64'($signed(dbx_reg[62:16])));
        c_next[11].by = cis_pkg::sat32(64'($signed(c_reg[10].by))
                                       + 64'($signed(dby_reg[62:16])));

        // stage 12..15: tangential dividend along t = (-ny, nx)
        rv2x_next = $signed(c_reg[11].bx) - $signed(c_reg[11].ax);
        rv2y_next = $signed(c_reg[11].by) - $signed(c_reg[11].ay);
        nny13     = -(19'($signed(c_reg[12].ny)));
        pt1_next  = rv2x_reg * nny13;
        pt2_next  = rv2y_reg * $signed(c_reg[12].nx);
        tn_next   = pt1_reg + pt2_reg;
        c_next[15].neg = tn_reg[52];
        mag_next  = tn_reg[52] ? -tn_reg : tn_reg;

        // stage 16..17: clamp magnitude to the friction bound, restore sign
        c_next[16] = d2_ctx;
        if (d2_ovf || d2_q > d2_ctx.maxf)
        begin
            jc_next = d2_ctx.maxf;
        end
        else
        begin
            jc_next = d2_q;
        end
        jt_next = c_reg[16].neg ? -$signed({1'b0, jc_reg}) : $signed({1'b0, jc_reg});

        // stage 18..19: friction impulse vector
        nny18    = -(19'($signed(c_reg[17].ny)));
        tpx_next = nny18 * jt_reg;
        tpy_next = $signed(c_reg[17].nx) * jt_reg;
        tix_next = cis_pkg::sat32(64'($signed(tpx_reg[52:16])));
        tiy_next = cis_pkg::sat32(64'($signed(tpy_reg[52:16])));

        // stage 20..21: weight by inverse mass and apply
        eax_next = tix_reg * $signed({1'b0, c_reg[19].ima});
        eay_next = tiy_reg * $signed({1'b0, c_reg[19].ima});
        ebx_next = tix_reg * $signed({1'b0, c_reg[19].imb});
        eby_next = tiy_reg * $signed({1'b0, c_reg[19].imb});
        c_next[21].ax = cis_pkg::sat32(64'($signed(c_reg[20].ax))
                                       + 64'($signed(eax_reg[62:16])));
        c_next[21].ay = cis_pkg::sat32(64'($signed(c_reg[20].ay))
                                       + 64'($signed(eay_reg[62:16])));
        c_next[21].bx = cis_pkg::sat32(64'($signed(c_reg[20].bx))
                                       - 64'($signed(ebx_reg[62:16])));
        c_next[21].by = cis_pkg::sat32(64'($signed(c_reg[20].by))
                                       - 64'($signed(eby_reg[62:16])));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 1; k <= 21; k++)
            begin
                c_reg[k] <= c_next[k];
            end
            for (int k = 1; k <= 3; k++)
            begin
                pen_reg[k] <= pen_next[k];
            end
            rvx_reg  <= rvx_next;
            rvy_reg  <= rvy_next;
            px_reg   <= px_next;
            py_reg   <= py_next;
            vn_reg   <= vn_next;
            num_reg  <= num_next;
            jq5_reg  <= jq5_next;
            jq6_reg  <= jq6_next;
            ps_reg   <= ps_next;
            pf_reg   <= pf_next;
            sc_reg   <= sc_next;
            cnx_reg  <= cnx_next;
            cny_reg  <= cny_next;
            ix_reg   <= ix_next;
            iy_reg   <= iy_next;
            dax_reg  <= dax_next;
            day_reg  <= day_next;
            dbx_reg  <= dbx_next;
            dby_reg  <= dby_next;
            rv2x_reg <= rv2x_next;
            rv2y_reg <= rv2y_next;
            pt1_reg  <= pt1_next;
            pt2_reg  <= pt2_next;
            tn_reg   <= tn_next;
            mag_reg  <= mag_next;
            jc_reg   <= jc_next;
            jt_reg   <= jt_next;
            tpx_reg  <= tpx_next;
            tpy_reg  <= tpy_next;
            tix_reg  <= tix_next;
            tiy_reg  <= tiy_next;
            eax_reg  <= eax_next;
            eay_reg  <= eay_next;
            ebx_reg  <= ebx_next;
            eby_reg  <= eby_next;
        end
    end

    // normal impulse magnitude, or position correction quotient
    cis_div u_div_n (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v_reg[4]),
        .in_ctx    (c_reg[4]),
        .dividend  (num_reg),
        .out_valid (d1_valid),
        .out_ctx   (d1_ctx),
        .quotient  (d1_q),
        .overflow  (d1_ovf)
    );

    // tangential impulse magnitude, truncated toward zero
    cis_div u_div_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v_reg[15]),
        .in_ctx    (c_reg[15]),
        .dividend  (mag_reg),
        .out_valid (d2_valid),
        .out_ctx   (d2_ctx),
        .quotient  (d2_q),
        .overflow  (d2_ovf)
    );

    // output register is the last stage
    assign out_valid = v_reg[21];
    assign new_a_x   = c_reg[21].ax;
    assign new_a_y   = c_reg[21].ay;
    assign new_b_x   = c_reg[21].bx;
    assign new_b_y   = c_reg[21].by;
    assign applied   = !c_reg[21].skip;

endmodule

>>> sv/cis_checker.sv
// port-level checker for the contact impulse solver, bound to the top level
module cis_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] new_a_x,
    input logic               applied
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(new_a_x) && $stable(applied))
        else $error("stalled result changed");

    // requests are taken exactly when the output side can move
    a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow output backpressure");

    // no result while reset is held
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result valid during reset");

endmodule

bind contact_impulse_solver_2d cis_checker u_cis_checker (.*);

>>> sim/tb_top.sv
// testbench for the 2d contact impulse solver: random and directed contacts vs a predictor
`timescale 1ns / 1ps

module tb_top;

    localparam int LATENCY = 89;
    localparam int N_RANDOM = 620;
    localparam longint CYCLE_LIMIT = 400000;

    // one contact request and its expected outcome
    typedef struct {
        logic               func;
        logic signed [31:0] ax, ay, bx, by;
        logic        [30:0] ima, imb;
        logic signed [17:0] nx, ny;
        logic        [16:0] e;
        logic        [17:0] mu;
        logic        [30:0] pen;
    } contact_t;

    typedef struct {
        logic signed [31:0] ax, ay, bx, by;
        logic               applied;
    } outcome_t;

    // fixed point helpers: floor shift and saturation
    function automatic longint floor16(longint v);
        return v >>> 16;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // scoreboard: holds resolved contacts in request order
    class contact_scoreboard;
        outcome_t pending[$];
        logic [16:0] slop_q;
        logic [16:0] pct_q;
        int errors;
        int checked;

        function new();
            slop_q = cis_pkg::SLOP_RESET;
            pct_q = cis_pkg::PCT_RESET;
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(logic idx, logic [16:0] val);
            if (idx == cis_pkg::REG_SLOP)
            begin
                slop_q = val;
            end
            else
            begin
                pct_q = val;
            end
        endfunction

        function outcome_t resolve(contact_t c);
            outcome_t r;
            longint ax, ay, bx, by, ia, ib, nx, ny, vn, j, ix, iy, jt, maxf, tix, tiy, dn;
            longint unsigned inv_sum, num, ju, p, q, s;
            ax = c.ax; ay = c.ay; bx = c.bx; by = c.by;
            ia = c.ima; ib = c.imb; nx = c.nx; ny = c.ny;
            inv_sum = c.ima + c.imb;
            r.applied = 1'b0;
            if (inv_sum != 0)
            begin
                if (c.func == cis_pkg::FUNC_VEL)
                begin
                    vn = floor16((bx - ax) * nx + (by - ay) * ny);
                    if (vn <= 0)
                    begin
                        num = (64'd65536 + c.e) * longint'(-vn);
                        ju = num / inv_sum;
                        j = (ju > 64'd2147483647) ? 64'sd2147483647 : longint'(ju);
                        ix = clamp32(floor16(j * nx));
                        iy = clamp32(floor16(j * ny));
                        ax = clamp32(ax - floor16(ix * ia));
                        ay = clamp32(ay - floor16(iy * ia));
                        bx = clamp32(bx + floor16(ix * ib));
                        by = clamp32(by + floor16(iy * ib));
                        // truncating division toward zero
                        dn = (bx - ax) * (-ny) + (by - ay) * nx;
                        if (dn < 0)
                        begin
                            jt = -longint'(longint'(-dn) / longint'(inv_sum));
                        end
                        else
                        begin
                            jt = dn / longint'(inv_sum);
                        end
                        maxf = longint'((longint'(c.mu) * j) >>> 16);
                        if (jt > maxf) jt = maxf;
                        if (jt < -maxf) jt = -maxf;
                        tix = clamp32(floor16((-ny) * jt));
                        tiy = clamp32(floor16(nx * jt));
                        ax = clamp32(ax + floor16(tix * ia));
                        ay = clamp32(ay + floor16(tiy * ia));
                        bx = clamp32(bx - floor16(tix * ib));
                        by = clamp32(by - floor16(tiy * ib));
                        r.applied = 1'b1;
                    end
                end
                else
                begin
                    p = (c.pen > slop_q) ? c.pen - slop_q : 0;
                    q = (p << 16) / inv_sum;
                    if (q > 64'd2147483647) q = 64'd2147483647;
                    s = (q * pct_q) >> 16;
                    if (s > 64'd2147483647) s = 64'd2147483647;
                    ix = clamp32(floor16(longint'(s) * nx));
                    iy = clamp32(floor16(longint'(s) * ny));
                    ax = clamp32(ax - floor16(ix * ia));
                    ay = clamp32(ay - floor16(iy * ia));
                    bx = clamp32(bx + floor16(ix * ib));
                    by = clamp32(by + floor16(iy * ib));
                    r.applied = 1'b1;
                end
            end
            r.ax = ax[31:0]; r.ay = ay[31:0]; r.bx = bx[31:0]; r.by = by[31:0];
            return r;
        endfunction

        function void note_request(contact_t c);
            pending.insert(pending.size(), resolve(c));
        endfunction

        task automatic report(string what, longint got, longint want);
            $display("mismatch on result %0d: %s got %0d expected %0d", checked, what, got, want);
            errors++;
        endtask

        task automatic check_result(outcome_t got);
            outcome_t want;
            if (pending.size() == 0)
            begin
                report("unexpected result", 1, 0);
                return;
            end
            want = pending.pop_front();
            if (got.ax !== want.ax) report("new_a_x", got.ax, want.ax);
            if (got.ay !== want.ay) report("new_a_y", got.ay, want.ay);
            if (got.bx !== want.bx) report("new_b_x", got.bx, want.bx);
            if (got.by !== want.by) report("new_b_y", got.by, want.by);
            if (got.applied !== want.applied) report("applied", got.applied, want.applied);
            checked++;
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    contact_t           req;
    logic               out_valid;
    logic               out_ready;
    outcome_t           res;
    logic               cfg_we;
    logic               cfg_index;
    logic        [16:0] cfg_data;

    contact_scoreboard sb;
    longint cycles;
    int sent;
    int n_vel, n_pos, n_applied;
    // idle pattern switches
    bit calm;
    bit hold_off;

    contact_impulse_solver_2d DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(req.func), .a_x(req.ax), .a_y(req.ay), .b_x(req.bx), .b_y(req.by),
        .inv_mass_a(req.ima), .inv_mass_b(req.imb),
        .normal_x(req.nx), .normal_y(req.ny),
        .restitution(req.e), .friction_coef(req.mu), .penetration(req.pen),
        .out_valid(out_valid), .out_ready(out_ready),
        .new_a_x(res.ax), .new_a_y(res.ay), .new_b_x(res.bx), .new_b_y(res.by),
        .applied(res.applied),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // cycle counter and timeout
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("tb_top failed");
                $finish;
            end
        end
    end

    // receiver: random back-pressure, plus one long hold-off window
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
            end
            else if (calm)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= 30);
            end
        end
    end

    // monitor: sample accepted results at the clock edge
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                sb.check_result(res);
            end
        end
    end

    // long receiver stall counted in its own process
    task automatic stall_receiver(int n);
        hold_off = 1'b1;
        repeat (n) @(posedge clk);
        hold_off = 1'b0;
    endtask

    // offer one request and hold it until accepted, with random idle first
    task automatic send_request(contact_t c);
        if (!calm)
        begin
            while ($urandom_range(99) < 30)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        req <= c;
        in_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        sb.note_request(c);
        sent++;
        if (c.func == cis_pkg::FUNC_VEL) n_vel++; else n_pos++;
    endtask

    // stop offering, drain, wait out the pipeline
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [16:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(2000) - 32'd1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rand_mass();
        case ($urandom_range(6))
            0: return 31'd0;
            1: return 31'h7FFF_FFFF;
            2: return 31'($urandom_range(65536 * 4));
            default: return 31'($urandom);
        endcase
    endfunction

    // mostly unit-ish normals, sometimes any 18 bit pattern
    function automatic logic [17:0] rand_normal();
        case ($urandom_range(4))
            0: return 18'($urandom);
            1: return $urandom_range(1) ? 18'sd65536 : -18'sd65536;
            default: return 18'($urandom_range(131072) - 32'd65536);
        endcase
    endfunction

    function automatic contact_t rand_contact();
        contact_t c;
        c.func = 1'($urandom_range(1));
        c.ax = rand_word(); c.ay = rand_word();
        c.bx = rand_word(); c.by = rand_word();
        c.ima = rand_mass(); c.imb = rand_mass();
        c.nx = rand_normal(); c.ny = rand_normal();
        c.e = ($urandom_range(7) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
        c.mu = ($urandom_range(7) == 0) ? 18'($urandom) : 18'($urandom_range(131072));
        c.pen = ($urandom_range(3) == 0) ? 31'($urandom_range(2000)) : 31'($urandom);
        return c;
    endfunction

    function automatic contact_t make_contact(logic f, longint ax, longint ay, longint bx,
                                              longint by, longint ima, longint imb,
                                              longint nx, longint ny, longint e,
                                              longint mu, longint pen);
        contact_t c;
        c.func = f; c.ax = 32'(ax); c.ay = 32'(ay); c.bx = 32'(bx); c.by = 32'(by);
        c.ima = 31'(ima); c.imb = 31'(imb); c.nx = 18'(nx); c.ny = 18'(ny);
        c.e = 17'(e); c.mu = 18'(mu); c.pen = 31'(pen);
        return c;
    endfunction

    initial
    begin
        contact_t c;
        sb = new();
        sent = 0; n_vel = 0; n_pos = 0;
        calm = 1'b0;
        hold_off = 1'b0;
        in_valid = 1'b0;
        req = make_contact(cis_pkg::FUNC_VEL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        cfg_we = 1'b0;
        cfg_index = cis_pkg::REG_SLOP;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: both static, separating, zero approach, head-on, extremes
        send_request(make_contact(cis_pkg::FUNC_VEL, 65536, 0, -65536, 0, 0, 0, 65536, 0,
                                  0, 0, 0));
        send_request(make_contact(cis_pkg::FUNC_VEL, -65536, 0, 65536, 0, 65536, 65536,
                                  65536, 0, 32768, 65536, 0));
        send_request(make_contact(cis_pkg::FUNC_VEL, 65536, 0, 65536, 0, 65536, 65536,
                                  65536, 0, 65536, 65536, 0));
        send_request(make_contact(cis_pkg::FUNC_VEL, 65536, 32768, -65536, 0, 65536, 0,
                                  65536, 0, 65536, 131072, 0));
        send_request(make_contact(cis_pkg::FUNC_VEL, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                  -32'sh80000000, -32'sh80000000, 31'h7FFFFFFF,
                                  31'h7FFFFFFF, -65536, -65536, 65536, 131072,
                                  31'h7FFFFFFF));
        send_request(make_contact(cis_pkg::FUNC_VEL, 32'h7FFFFFFF, 0, -32'sh80000000, 0,
                                  1, 1, 65536, 0, 17'h1FFFF, 18'h3FFFF, 0));
        send_request(make_contact(cis_pkg::FUNC_VEL, 100, -100, -100, 100, 3, 0,
                                  18'h1FFFF, 18'h20000, 0, 0, 0));
        send_request(make_contact(cis_pkg::FUNC_POS, 0, 0, 0, 0, 0, 0, 65536, 0, 0, 0,
                                  65536));
        send_request(make_contact(cis_pkg::FUNC_POS, 0, 0, 0, 0, 65536, 65536, 0, 65536,
                                  0, 0, 600));
        send_request(make_contact(cis_pkg::FUNC_POS, 0, 0, 0, 0, 65536, 65536, 0, 65536,
                                  0, 0, 655));
        send_request(make_contact(cis_pkg::FUNC_POS, 10, 20, 30, 40, 65536, 0, 46341,
                                  46341, 0, 0, 131072));
        send_request(make_contact(cis_pkg::FUNC_POS, 32'h7FFFFFFF, -32'sh80000000,
                                  -32'sh80000000, 32'h7FFFFFFF, 31'h7FFFFFFF,
                                  31'h7FFFFFFF, -65536, 65536, 0, 0, 31'h7FFFFFFF));
        send_request(make_contact(cis_pkg::FUNC_POS, 0, 0, 0, 0, 1, 0, 18'h1FFFF,
                                  18'h20000, 0, 0, 31'h7FFFFFFF));
        drain();

        // register extremes with position requests
        for (int k = 0; k < 4; k++)
        begin
            write_reg(cis_pkg::REG_SLOP, (k == 0) ? 17'd0 : (k == 1) ? 17'd65536 :
                      (k == 2) ? 17'h1FFFF : 17'($urandom_range(65536)));
            write_reg(cis_pkg::REG_PCT, (k == 0) ? 17'd65536 : (k == 1) ? 17'd0 :
                      (k == 2) ? 17'h1FFFF : 17'($urandom_range(65536)));
            for (int i = 0; i < 30; i++)
            begin
                c = rand_contact();
                c.func = cis_pkg::FUNC_POS;
                send_request(c);
            end
            drain();
        end
        write_reg(cis_pkg::REG_SLOP, cis_pkg::SLOP_RESET);
        write_reg(cis_pkg::REG_PCT, cis_pkg::PCT_RESET);

        // random phase: calm stretch, then a long receiver stall, then idling
        for (int i = 0; i < N_RANDOM; i++)
        begin
            calm = (i >= 100 && i < 250);
            if (i == 300)
            begin
                fork
                    stall_receiver(400);
                join_none
            end
            send_request(rand_contact());
        end
        calm = 1'b0;

        drain();
        n_applied = sb.checked;
        $display("ran %0d contacts (%0d velocity, %0d position) under five register settings",
                 sent, n_vel, n_pos);
        $display("%0d results compared, %0d mismatches", n_applied, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

>>> files.f
sv/cis_pkg.sv
sv/cis_div.sv
sv/contact_impulse_solver_2d.sv
sv/cis_checker.sv
sim/tb_top.sv
